[rtl/core/bdpc_pkg.sv]
package bdpc_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int COLS_FIELD_W = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } cfg_reg_t;

    // Result count
    localparam int                 COUNT_W   = 26;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // One line buffer entry: the two rows above the current one at a column
    typedef struct packed {
        logic mid;  // row two above the incoming row, for the next pass
        logic cur;  // row one above the incoming row, for the next pass
    } line_word_t;

endpackage

[rtl/core/bdpc_line_buf.sv]
// Two-row line buffer: one write port, one registered read port.
// A read of the address written in the same cycle returns the new data.
module bdpc_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  bdpc_pkg::line_word_t  wr_data,
    input  logic [AW-1:0]         rd_addr,
    output bdpc_pkg::line_word_t  rd_data
);

    bdpc_pkg::line_word_t line_mem_reg [DEPTH];
    bdpc_pkg::line_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= line_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/binary_dilation_pixel_counter_top.sv]
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------
// in       | input     | in_valid/in_stall  | cell_set (1 bit)
// out      | output    | out_valid/out_stall| covered_count (26 bits)
// cfg      | input     | cfg_we             | cfg_index (1 bit), cfg_data (16 bits)
//
// One item per clock while no frame end is held back. The whole 3x3 window
// update and the count add run in the accept cycle; the line buffer is read
// ahead at the next column, with bypass for a write to the same column.
// Reset (rst_n, async, active low) clears positions, window, count and the
// geometry (1x1); the line buffer holds no reset and needs no clearing pass.
// out_stall only holds back an item that closes a frame while a count waits.
module binary_dilation_pixel_counter_top #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 65535
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [bdpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // cells in
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cell_set,
    // count out
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bdpc_pkg::COUNT_W-1:0]      covered_count
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS + 1);

    // Window layout: three 3-bit column groups, bit0 upper, bit1 middle,
    // bit2 current row. Masks pick cells whose neighborhood is in view.
    localparam logic [8:0] MASK_ALL      = 9'h1FF;
    localparam logic [8:0] MASK_OLD2     = 9'h03F;
    localparam logic [8:0] MASK_LOW      = 9'h1B6;
    localparam logic [8:0] MASK_OLD2_LOW = 9'h036;

    // geometry, stored as last index
    logic [RW-1:0] rows_last_reg, rows_last_next;
    logic [CW-1:0] cols_last_reg, cols_last_next;
    logic [31:0]   rows_lim, cols_lim;

    // stream state
    logic [CW-1:0]               col_reg, col_next;
    logic [RW-1:0]               row_reg, row_next;
    logic [8:0]                  window_reg, window_next;
    logic [bdpc_pkg::COUNT_W-1:0] total_reg, total_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [bdpc_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                  in_accept;
    logic                  row_end, last_row, frame_end;
    logic                  up_bit, mid_bit;
    logic [2:0]            inc;
    logic [bdpc_pkg::COUNT_W:0] sum;
    logic [bdpc_pkg::COUNT_W-1:0] sat_sum;
    logic [CW-1:0]         rd_addr;
    bdpc_pkg::line_word_t  rd_word, wr_word;

    // ---------------- configuration ----------------
    always_comb
    begin
        rows_lim = 32'(cfg_data);
        priority if (rows_lim == 32'd0)
            rows_lim = 32'd1;
        else if (rows_lim > 32'(MAX_ROWS))
            rows_lim = 32'(MAX_ROWS);
        rows_last_next = RW'(rows_lim - 32'd1);

        cols_lim = 32'(cfg_data[bdpc_pkg::COLS_FIELD_W-1:0]);
        priority if (cols_lim == 32'd0)
            cols_lim = 32'd1;
        else if (cols_lim > 32'(MAX_COLS))
            cols_lim = 32'(MAX_COLS);
        cols_last_next = CW'(cols_lim - 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_last_reg <= '0;
            cols_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bdpc_pkg::REG_FRAME_ROWS: rows_last_reg <= rows_last_next;
                bdpc_pkg::REG_FRAME_COLS: cols_last_reg <= cols_last_next;
                default: ;
            endcase
        end
    end

    // ---------------- position and handshake ----------------
    assign row_end   = (col_reg >= cols_last_reg);
    assign last_row  = (row_reg >= rows_last_reg);
    assign frame_end = row_end && last_row;

    // Only a frame-closing item needs room in the result register.
    assign in_stall  = out_valid_reg && out_stall && frame_end;
    assign in_accept = in_valid && !in_stall;

    // Line buffer is read for the column the next item will land on.
    assign col_next = row_end ? '0 : (col_reg + CW'(1));
    assign row_next = row_end ? (last_row ? '0 : (row_reg + RW'(1))) : row_reg;
    assign rd_addr  = in_accept ? col_next : col_reg;

    // Rows above the top edge read as clear.
    assign up_bit  = (row_reg >= RW'(2)) ? rd_word.mid : 1'b0;
    assign mid_bit = (row_reg != '0)     ? rd_word.cur : 1'b0;

    assign wr_word.mid = mid_bit;
    assign wr_word.cur = cell_set;

    bdpc_line_buf #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (col_reg),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // ---------------- window and count ----------------
    always_comb
    begin
        window_next = (col_reg == '0) ? 9'h000 : {window_reg[5:0], 3'b000};
        window_next = window_next | {6'b0, cell_set, mid_bit, up_bit};

        // Middle-row cell one column back: full neighborhood in view.
        // At row end the last column is closed too. On the last row the
        // current-row cells close with no row below.
        inc = '0;
        if ((row_reg != '0) && (col_reg != '0))
            inc = inc + 3'(|(window_next & MASK_ALL));
        if ((row_reg != '0) && row_end)
            inc = inc + 3'(|(window_next & MASK_OLD2));
        if (last_row && (col_reg != '0))
            inc = inc + 3'(|(window_next & MASK_LOW));
        if (last_row && row_end)
            inc = inc + 3'(|(window_next & MASK_OLD2_LOW));

        sum     = {1'b0, total_reg} + (bdpc_pkg::COUNT_W+1)'(inc);
        sat_sum = sum[bdpc_pkg::COUNT_W] ? bdpc_pkg::COUNT_MAX
                                         : sum[bdpc_pkg::COUNT_W-1:0];
        total_next = frame_end ? '0 : sat_sum;
    end

    // ---------------- result register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        count_next     = count_reg;
        if (in_accept && frame_end)
        begin
            out_valid_next = 1'b1;
            count_next     = sat_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            window_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                window_reg <= window_next;
                total_reg  <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign out_valid     = out_valid_reg;
    assign covered_count = count_reg;

endmodule

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 65535;

    // Random cells per idling phase; the directed frames come on top.
    localparam int PHASE_ITEMS = 180;

    // Every update lands in the accept cycle, so this short settle after the
    // last count is plenty before touching the geometry again.
    localparam int SETTLE_CYCLES = 8;

    // About 1.9k cells in all. Every geometry change adds a drain and two
    // writes, so a correct run stays far inside this limit even with long
    // receiver stalls on every count.
    localparam int CYCLE_LIMIT = 200_000;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [bdpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic                             cell_set  = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [bdpc_pkg::COUNT_W-1:0]     covered_count;

    binary_dilation_pixel_counter_top #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cell_set     (cell_set),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .covered_count(covered_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Cells waiting for the driver, and counts waiting for the DUT.
    logic                         pending_cells [$];
    logic [bdpc_pkg::COUNT_W-1:0] expected_counts [$];

    int unsigned send_idle_pct = 38;
    int unsigned recv_idle_pct = 83;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    logic        in_taken      = 1'b0;

    // Set-cell densities a frame is drawn with, in percent.
    int unsigned density_pct [6] = '{0, 4, 15, 40, 75, 100};

    // ------------------------------------------------------------------
    // Shadow of the dilation counter: geometry, two line rows, the 3x3
    // window and the raster position. Reset values match the DUT's.
    // ------------------------------------------------------------------
    logic [bdpc_pkg::CFG_DATA_W-1:0]   rows_cfg = 16'd1;
    logic [bdpc_pkg::COLS_FIELD_W-1:0] cols_cfg = 11'd1;
    logic                              upper_row  [MAX_COLS];
    logic                              middle_row [MAX_COLS];
    logic [8:0]                        window     = '0;
    int unsigned                       row_pos    = 0;
    int unsigned                       col_pos    = 0;
    logic [bdpc_pkg::COUNT_W-1:0]      area_total = '0;

    function automatic void add_covered(input logic hit);
        if (hit && area_total != bdpc_pkg::COUNT_MAX)
            area_total++;
    endfunction

    // Advance the shadow by one accepted cell; a frame's last cell queues
    // the count the DUT must report.
    function automatic void track_cell(input logic cur);
        int unsigned rows;
        int unsigned cols;
        int unsigned idx;
        logic        up;
        logic        mid;
        logic        row_end;
        logic        last_row;

        // A zero register acts as one; oversize values clamp to MAX_ROWS and MAX_COLS.
        rows = (rows_cfg == 0) ? 1 : ((rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg);
        cols = (cols_cfg == 0) ? 1 : ((cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg);
        idx  = (col_pos < MAX_COLS) ? col_pos : MAX_COLS - 1;
        up   = (row_pos >= 2) ? upper_row[idx]  : 1'b0;
        mid  = (row_pos >= 1) ? middle_row[idx] : 1'b0;
        row_end  = (col_pos + 1 >= cols);
        last_row = (row_pos + 1 >= rows);

        // Window columns are 3-bit groups {current, middle, upper}, newest low.
        if (col_pos == 0)
            window = '0;
        window = {window[5:0], cur, mid, up};

        // Middle row cells are decided with the row below in view.
        if (row_pos >= 1)
        begin
            if (col_pos >= 1)
                add_covered(window != 0);
            if (row_end)
                add_covered(window[5:0] != 0);
        end
        // Last row has nothing below it: decide it as it streams in.
        if (last_row)
        begin
            if (col_pos >= 1)
                add_covered((window & 9'h1B6) != 0);
            if (row_end)
                add_covered((window & 9'h036) != 0);
        end

        upper_row[idx]  = mid;
        middle_row[idx] = cur;

        if (!row_end)
            col_pos++;
        else
        begin
            col_pos = 0;
            if (!last_row)
                row_pos++;
            else
            begin
                expected_counts.insert(expected_counts.size(), area_total);
                area_total = '0;
                row_pos    = 0;
                window     = '0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: new cell at the falling edge once the previous item is
    // taken; a stalled item holds. The receiver side draws its stall here.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    cell_set <= pending_cells.pop_front();
                end
                else
                begin
                    // idle cycle: junk on the payload
                    in_valid <= 1'b0;
                    cell_set <= 1'($urandom);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. Accepted cells go
    // through the shadow; accepted counts are checked in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [bdpc_pkg::COUNT_W-1:0] want;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                track_cell(cell_set);
            if (out_valid && !out_stall)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: unexpected count, expected none, actual %0d",
                             $realtime, covered_count);
                    error_count++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (covered_count !== want)
                    begin
                        $display("%0t: covered_count mismatch, expected %0d, actual %0d",
                                 $realtime, want, covered_count);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Block until every queued cell is taken and every count has come,
    // then let the design settle for SETTLE_CYCLES.
    task automatic wait_drained();
        while (pending_cells.size() != 0 || in_valid || expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bdpc_pkg::cfg_reg_t index,
                             input logic [bdpc_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        if (index == bdpc_pkg::REG_FRAME_ROWS)
            rows_cfg = data;
        else
            cols_cfg = data[bdpc_pkg::COLS_FIELD_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Geometry only moves between frames, with the DUT idle.
    task automatic set_geometry(input int rows, input int cols);
        logic [bdpc_pkg::CFG_DATA_W-1:0] cols_word;
        wait_drained();
        write_reg(bdpc_pkg::REG_FRAME_ROWS, rows[bdpc_pkg::CFG_DATA_W-1:0]);
        // bits above the column field are noise the DUT must drop
        cols_word = bdpc_pkg::CFG_DATA_W'($urandom);
        cols_word[bdpc_pkg::COLS_FIELD_W-1:0] = cols[bdpc_pkg::COLS_FIELD_W-1:0];
        write_reg(bdpc_pkg::REG_FRAME_COLS, cols_word);
    endtask

    // Queue one whole frame at a random density; returns its cell count.
    function automatic int queue_frame(input int rows, input int cols);
        int unsigned cells;
        int unsigned density;
        cells = ((rows == 0) ? 1 : rows) *
                ((cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols));
        density = density_pct[$urandom_range(5)];
        repeat (cells)
            pending_cells.insert(pending_cells.size(), $urandom_range(99) < density);
        return cells;
    endfunction

    // Directed cells, leftmost bit first in raster order.
    function automatic void queue_pattern(input int n, input logic [15:0] pattern);
        for (int i = n - 1; i >= 0; i--)
            pending_cells.insert(pending_cells.size(), pattern[i]);
    endfunction

    // One idling phase: a large frame, then small random geometries with
    // a few frames each. Some groups wait for every count after each frame.
    task automatic run_phase(input int send_pct, input int recv_pct,
                             input int big_rows, input int big_cols);
        int unsigned sent;
        int unsigned rows;
        int unsigned cols;
        int unsigned frames;
        logic        drain_each;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_geometry(big_rows, big_cols);
        void'(queue_frame(big_rows, big_cols));
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            rows = ($urandom_range(11) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 5);
            cols = ($urandom_range(11) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 10);
            set_geometry(rows, cols);
            frames     = $urandom_range(1, 4);
            drain_each = (sent == 0) || ($urandom_range(3) == 0);
            for (int f = 0; f < frames && sent < PHASE_ITEMS; f++)
            begin
                sent += queue_frame(rows, cols);
                if (drain_each)
                    wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset geometry is 1x1: a lone set cell, then a lone clear one.
        queue_pattern(2, 16'b10);
        // Zero registers act as one.
        set_geometry(0, 0);
        queue_pattern(2, 16'b01);
        // Center cell of a 3x3 frame covers all nine.
        set_geometry(3, 3);
        queue_pattern(9, 16'b000_010_000);
        // Single row: decided as it streams, no row below.
        set_geometry(1, 4);
        queue_pattern(4, 16'b1001);
        // Single column: last cell of each row closes at row end.
        set_geometry(4, 1);
        queue_pattern(4, 16'b0010);

        // Oversize column count clamps to the full line buffer width; then
        // a tall single-column frame; then a narrow frame with no idling.
        run_phase(38, 83, 1, 2047);
        run_phase(83, 38, 120, 1);
        run_phase(0, 0, 40, 3);

        wait_drained();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[binary_dilation_pixel_counter_top.f]
rtl/core/bdpc_pkg.sv
rtl/core/bdpc_line_buf.sv
rtl/core/binary_dilation_pixel_counter_top.sv
dv/tb.sv
